// ----- hdl/resp_stream_parser_unit_defines.svh -----
// Assertion macros shared by the parser RTL
`ifndef RESP_STREAM_PARSER_UNIT_DEFINES_SVH
`define RESP_STREAM_PARSER_UNIT_DEFINES_SVH

// same-cycle implication, clocked on aclk, off while aresetn is low
`define RSP_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, clocked on aclk, off while aresetn is low
`define RSP_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/rsp_pkg.sv -----
// Shared types and constants of the reply stream parser
package rsp_pkg;

    typedef enum logic [3:0] {
        PS_START, PS_SIMPLE, PS_SIMPLE_LF, PS_ERRSTR, PS_ERRSTR_LF,
        PS_INT, PS_INT_LF, PS_BSIZE, PS_BSIZE_LF, PS_BULK, PS_BULK_CR,
        PS_BULK_LF, PS_ASIZE, PS_ASIZE_LF
    } parse_state_t;

    typedef enum logic [3:0] {
        EV_NONE, EV_SBYTE, EV_EBYTE, EV_BBYTE, EV_SEND, EV_EEND, EV_INT,
        EV_BEND, EV_NIL, EV_ARRAY, EV_EMPTY, EV_ERROR
    } event_t;

    typedef enum logic {
        CT_IDLE, CT_UNWIND
    } ctrl_state_t;

    typedef struct packed {
        logic step;     // parse the byte on the input beat
        logic unwind;   // one array-close step from the stack memory
    } dp_cmd_t;

    typedef struct packed {
        logic unwind_more;  // another array level must be closed
    } dp_status_t;

    localparam int EV_W   = 4;
    localparam int BYTE_W = 8;
    localparam int INT_W  = 64;
    localparam int LEN_W  = 31;
    localparam int CNT_W  = 4;

    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TILDE  = 8'h7E;

    localparam logic [63:0] LEN_MAX = 64'h0000_0000_7FFF_FFFF;
    localparam logic [63:0] LEN_SAT = 64'h0000_0000_8000_0000;

endpackage

// ----- hdl/resp_stream_parser_unit.sv -----
// Top level of the reply stream parser: byte beats in, one event beat out per byte
//
//  channel | dir | tdata                                   | tuser      | tlast
//  s_      | in  | [7:0] rx byte                           | -          | -
//  m_      | out | data, int, array len, closed, depth     | [3:0] event| message done
//
// A byte that closes an array level while a level below stays open is followed by
// unwind steps, each of which is one read of the stack memory.
// Synchronous reset; bytes are taken from the first cycle after aresetn rises.
// The result sits in an output register, so a new beat is taken in the cycle
// the previous result leaves; m_tready low holds the result and stalls s_tready.
module resp_stream_parser_unit import rsp_pkg::*; #(
    parameter int MAX_DEPTH = 8
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [7:0]    s_tdata,   // [7:0] rx_byte
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [111:0]  m_tdata,   // [7:0] data_byte, [71:8] int_value,
                                     // [102:72] array_length, [106:103] arrays_closed,
                                     // [110:107] nest_depth, [111] zero
    output logic [3:0]    m_tuser,   // [3:0] event_res
    output logic          m_tlast    // message_done
);

    dp_cmd_t                 cmd;
    dp_status_t              sts;
    logic [EV_W-1:0]         event_res;
    logic [BYTE_W-1:0]       data_byte;
    logic signed [INT_W-1:0] int_value;
    logic [LEN_W-1:0]        array_length;
    logic [CNT_W-1:0]        arrays_closed;
    logic                    message_done;
    logic [CNT_W-1:0]        nest_depth;

    rsp_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

    rsp_datapath #(
        .MAX_DEPTH (MAX_DEPTH)
    ) u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .sts           (sts),
        .rx_byte       (s_tdata),
        .event_res     (event_res),
        .data_byte     (data_byte),
        .int_value     (int_value),
        .array_length  (array_length),
        .arrays_closed (arrays_closed),
        .message_done  (message_done),
        .nest_depth    (nest_depth)
    );

    assign m_tdata = {1'b0, nest_depth, arrays_closed, array_length, int_value, data_byte};
    assign m_tuser = event_res;
    assign m_tlast = message_done;

endmodule

// ----- hdl/rsp_ctrl.sv -----
// Handshake controller: accepts beats, sequences array unwinding, owns m_tvalid
module rsp_ctrl import rsp_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    output logic       m_tvalid,
    input  logic       m_tready,
    output dp_cmd_t    cmd,
    input  dp_status_t sts
);

`include "resp_stream_parser_unit_defines.svh"

    ctrl_state_t state_reg, state_next;
    logic        m_tvalid_reg, m_tvalid_next;
    logic        load;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= CT_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        load       = 1'b0;
        s_tready   = 1'b0;
        unique case (state_reg)
            CT_IDLE: begin
                // no beat is taken while reset is held
                s_tready = aresetn && (!m_tvalid_reg || m_tready);
                cmd.step = s_tready && s_tvalid;
                if (cmd.step) begin
                    if (sts.unwind_more) begin
                        state_next = CT_UNWIND;
                    end else begin
                        load = 1'b1;
                    end
                end
            end
            CT_UNWIND: begin
                cmd.unwind = 1'b1;
                if (!sts.unwind_more) begin
                    state_next = CT_IDLE;
                    load       = 1'b1;
                end
            end
            default: begin
                state_next = CT_IDLE;
            end
        endcase
        if (load) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end else begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;

    `RSP_ASSERT_IMP(a_unwind_out_empty, state_reg == CT_UNWIND, !m_tvalid_reg, "result pending during unwind")
    `RSP_ASSERT_NXT(a_step_result, cmd.step && !sts.unwind_more, m_tvalid_reg && state_reg == CT_IDLE, "simple beat gave no result")
    `RSP_ASSERT_NXT(a_unwind_end, state_reg == CT_UNWIND && !sts.unwind_more, m_tvalid_reg && state_reg == CT_IDLE, "unwind end gave no result")

endmodule

// ----- hdl/rsp_datapath.sv -----
// Parse datapath: state, number accumulator, bulk counter, element-count stack
module rsp_datapath import rsp_pkg::*; #(
    parameter int MAX_DEPTH = 8
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  dp_cmd_t                 cmd,
    output dp_status_t              sts,
    input  logic [BYTE_W-1:0]       rx_byte,
    output logic [EV_W-1:0]         event_res,
    output logic [BYTE_W-1:0]       data_byte,
    output logic signed [INT_W-1:0] int_value,
    output logic [LEN_W-1:0]        array_length,
    output logic [CNT_W-1:0]        arrays_closed,
    output logic                    message_done,
    output logic [CNT_W-1:0]        nest_depth
);

`include "resp_stream_parser_unit_defines.svh"

    localparam int LW = $clog2(MAX_DEPTH + 1);
    localparam int AW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

    parse_state_t      ps_reg, ps_next;
    logic [63:0]       acc_reg, acc_next;
    logic              neg_reg, neg_next;
    logic              dig_reg, dig_next;
    logic [LEN_W-1:0]  bulk_reg, bulk_next;
    logic [LW-1:0]     lvl_reg, lvl_next;
    logic [LEN_W-1:0]  top_reg, top_next;
    logic [LEN_W-1:0]  rd_reg;
    logic [LEN_W-1:0]  stack_mem [MAX_DEPTH];

    event_t            ev_reg, ev;
    logic [BYTE_W-1:0] data_reg, data_b;
    logic [INT_W-1:0]  ival_reg, ival;
    logic [LEN_W-1:0]  alen_reg, alen;
    logic [LW-1:0]     closed_reg, closed_next;
    logic              done_reg, done_next;

    logic              ended, err, push, more, rd_en;
    logic [7:0]        digit;
    logic              is_digit, is_cr, is_lf, is_print;
    logic [63:0]       acc_x10, acc_sat;
    logic [LEN_W-1:0]  bulk_dec, cnt_src, cnt_dec;
    logic [LW-1:0]     rd_full, wr_full;
    logic [AW-1:0]     rd_addr, wr_addr;
    logic [LW+3:0]     depth_ext, closed_ext;

    assign digit    = rx_byte - CH_ZERO;
    assign is_digit = (rx_byte >= CH_ZERO) && (rx_byte <= CH_NINE);
    assign is_cr    = (rx_byte == CH_CR);
    assign is_lf    = (rx_byte == CH_LF);
    assign is_print = (rx_byte >= CH_SPACE) && (rx_byte <= CH_TILDE);

    // x*10 + d as two shifted terms
    assign acc_x10 = {acc_reg[60:0], 3'b000} + {acc_reg[62:0], 1'b0} + {60'd0, digit[3:0]};
    always_comb begin
        if (acc_reg >= LEN_SAT) begin
            acc_sat = LEN_SAT;
        end else if (acc_x10 > LEN_SAT) begin
            acc_sat = LEN_SAT;
        end else begin
            acc_sat = acc_x10;
        end
    end

    assign bulk_dec = bulk_reg - LEN_W'(bulk_reg != '0);
    // element count under decrement: cached top on a beat, memory word while unwinding
    assign cnt_src  = cmd.unwind ? rd_reg : top_reg;
    assign cnt_dec  = cnt_src - LEN_W'(cnt_src != '0);
    assign rd_full  = lvl_reg - LW'(2);
    assign wr_full  = lvl_reg - LW'(1);
    assign rd_addr  = rd_full[AW-1:0];
    assign wr_addr  = wr_full[AW-1:0];

    always_comb begin
        ps_next     = ps_reg;
        acc_next    = acc_reg;
        neg_next    = neg_reg;
        dig_next    = dig_reg;
        bulk_next   = bulk_reg;
        lvl_next    = lvl_reg;
        top_next    = top_reg;
        closed_next = closed_reg;
        done_next   = done_reg;
        ev          = EV_NONE;
        data_b      = '0;
        ival        = '0;
        alen        = '0;
        ended       = 1'b0;
        err         = 1'b0;
        push        = 1'b0;
        more        = 1'b0;
        rd_en       = 1'b0;

        if (cmd.step) begin
            unique case (ps_reg)
                PS_START: begin
                    acc_next = '0;
                    neg_next = 1'b0;
                    dig_next = 1'b0;
                    priority if (rx_byte == CH_PLUS) begin
                        ps_next = PS_SIMPLE;
                    end else if (rx_byte == CH_MINUS) begin
                        ps_next = PS_ERRSTR;
                    end else if (rx_byte == CH_COLON) begin
                        ps_next = PS_INT;
                    end else if (rx_byte == CH_DOLLAR) begin
                        ps_next = PS_BSIZE;
                    end else if (rx_byte == CH_STAR) begin
                        ps_next = PS_ASIZE;
                    end else begin
                        err = 1'b1;
                    end
                end
                PS_SIMPLE, PS_ERRSTR: begin
                    if (is_cr) begin
                        ps_next = (ps_reg == PS_SIMPLE) ? PS_SIMPLE_LF : PS_ERRSTR_LF;
                    end else if (is_print) begin
                        ev     = (ps_reg == PS_SIMPLE) ? EV_SBYTE : EV_EBYTE;
                        data_b = rx_byte;
                    end else begin
                        err = 1'b1;
                    end
                end
                PS_SIMPLE_LF, PS_ERRSTR_LF, PS_BULK_LF: begin
                    if (is_lf) begin
                        ev = (ps_reg == PS_SIMPLE_LF) ? EV_SEND :
                             (ps_reg == PS_ERRSTR_LF) ? EV_EEND : EV_BEND;
                        ended   = 1'b1;
                        ps_next = PS_START;
                    end else begin
                        err = 1'b1;
                    end
                end
                PS_INT, PS_BSIZE, PS_ASIZE: begin
                    if (is_cr) begin
                        if (!dig_reg) begin
                            err = 1'b1;
                        end else begin
                            ps_next = (ps_reg == PS_INT)   ? PS_INT_LF :
                                      (ps_reg == PS_BSIZE) ? PS_BSIZE_LF : PS_ASIZE_LF;
                        end
                    end else if (is_digit) begin
                        acc_next = (ps_reg == PS_INT) ? acc_x10 : acc_sat;
                        dig_next = 1'b1;
                    end else if (rx_byte == CH_MINUS && !dig_reg && !neg_reg) begin
                        neg_next = 1'b1;
                    end else begin
                        err = 1'b1;
                    end
                end
                PS_INT_LF: begin
                    if (is_lf) begin
                        ival     = neg_reg ? (64'd0 - acc_reg) : acc_reg;
                        ev       = EV_INT;
                        ended    = 1'b1;
                        ps_next  = PS_START;
                        acc_next = '0;
                        neg_next = 1'b0;
                        dig_next = 1'b0;
                    end else begin
                        err = 1'b1;
                    end
                end
                PS_BSIZE_LF, PS_ASIZE_LF: begin
                    if (!is_lf) begin
                        err = 1'b1;
                    end else if (neg_reg && acc_reg == 64'd1) begin
                        ev      = EV_NIL;
                        ended   = 1'b1;
                        ps_next = PS_START;
                    end else if (neg_reg && acc_reg != '0) begin
                        err = 1'b1;
                    end else if (acc_reg > LEN_MAX) begin
                        err = 1'b1;
                    end else if (acc_reg == '0) begin
                        if (ps_reg == PS_ASIZE_LF) begin
                            ev      = EV_EMPTY;
                            ended   = 1'b1;
                            ps_next = PS_START;
                        end else begin
                            ps_next = PS_BULK_CR;
                        end
                    end else if (ps_reg == PS_ASIZE_LF) begin
                        if (lvl_reg >= LW'(MAX_DEPTH)) begin
                            err = 1'b1;
                        end else begin
                            push     = 1'b1;
                            top_next = acc_reg[LEN_W-1:0];
                            lvl_next = lvl_reg + LW'(1);
                            ev       = EV_ARRAY;
                            alen     = acc_reg[LEN_W-1:0];
                            ps_next  = PS_START;
                        end
                    end else begin
                        bulk_next = acc_reg[LEN_W-1:0];
                        ps_next   = PS_BULK;
                    end
                    if (!err) begin
                        acc_next = '0;
                        neg_next = 1'b0;
                        dig_next = 1'b0;
                    end
                end
                PS_BULK: begin
                    ev        = EV_BBYTE;
                    data_b    = rx_byte;
                    bulk_next = bulk_dec;
                    if (bulk_dec == '0) begin
                        ps_next = PS_BULK_CR;
                    end
                end
                PS_BULK_CR: begin
                    if (is_cr) begin
                        ps_next = PS_BULK_LF;
                    end else begin
                        err = 1'b1;
                    end
                end
                default: begin
                    err = 1'b1;
                end
            endcase

            closed_next = '0;
            done_next   = 1'b0;
            if (err) begin
                ps_next   = PS_START;
                acc_next  = '0;
                neg_next  = 1'b0;
                dig_next  = 1'b0;
                bulk_next = '0;
                lvl_next  = '0;
                ev        = EV_ERROR;
                data_b    = '0;
                ival      = '0;
                alen      = '0;
            end else if (ended) begin
                if (lvl_reg == '0) begin
                    done_next = 1'b1;
                end else if (cnt_dec != '0) begin
                    top_next = cnt_dec;
                end else begin
                    lvl_next    = lvl_reg - LW'(1);
                    closed_next = LW'(1);
                    if (lvl_reg == LW'(1)) begin
                        done_next = 1'b1;
                    end else begin
                        more  = 1'b1;
                        rd_en = 1'b1;
                    end
                end
            end
        end else if (cmd.unwind) begin
            // rd_reg holds the count of the level now on top
            if (cnt_dec != '0) begin
                top_next = cnt_dec;
            end else begin
                lvl_next    = lvl_reg - LW'(1);
                closed_next = closed_reg + LW'(1);
                if (lvl_reg == LW'(1)) begin
                    done_next = 1'b1;
                end else begin
                    more  = 1'b1;
                    rd_en = 1'b1;
                end
            end
        end
    end

    assign sts.unwind_more = more;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ps_reg   <= PS_START;
            acc_reg  <= '0;
            neg_reg  <= 1'b0;
            dig_reg  <= 1'b0;
            bulk_reg <= '0;
            lvl_reg  <= '0;
        end else begin
            ps_reg   <= ps_next;
            acc_reg  <= acc_next;
            neg_reg  <= neg_next;
            dig_reg  <= dig_next;
            bulk_reg <= bulk_next;
            lvl_reg  <= lvl_next;
        end
    end

    always_ff @(posedge aclk) begin
        top_reg     <= top_next;
        closed_reg  <= closed_next;
        done_reg    <= done_next;
        if (cmd.step) begin
            ev_reg   <= ev;
            data_reg <= data_b;
            ival_reg <= ival;
            alen_reg <= alen;
        end
    end

    // levels below the top live here; the top is cached in top_reg
    always_ff @(posedge aclk) begin
        if (push && lvl_reg != '0) begin
            stack_mem[wr_addr] <= top_reg;
        end
        if (rd_en) begin
            rd_reg <= stack_mem[rd_addr];
        end
    end

    assign depth_ext     = {4'b0000, lvl_reg};
    assign closed_ext    = {4'b0000, closed_reg};
    assign event_res     = ev_reg;
    assign data_byte     = data_reg;
    assign int_value     = ival_reg;
    assign array_length  = alen_reg;
    assign arrays_closed = closed_ext[CNT_W-1:0];
    assign message_done  = done_reg;
    assign nest_depth    = depth_ext[CNT_W-1:0];

    `RSP_ASSERT_IMP(a_depth_bound, 1'b1, lvl_reg <= LW'(MAX_DEPTH), "nesting level above limit")
    `RSP_ASSERT_NXT(a_err_clears, cmd.step && err, lvl_reg == '0 && ps_reg == PS_START, "error did not reset parser")
    `RSP_ASSERT_IMP(a_bulk_nonzero, ps_reg == PS_BULK, bulk_reg != '0, "bulk body with zero count")

endmodule

// ----- dv/tb_resp_stream_parser_unit.sv -----
// Self-checking bench for the reply stream parser: byte beats in, event beats checked in order
module tb_resp_stream_parser_unit import rsp_pkg::*; ();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int PARSE_DEPTH = 8;
    localparam int STALL_LIMIT = 2000;
    localparam int IDLE_PCT    = 12;

    typedef struct packed {
        event_t      ev;
        logic [7:0]  data;
        logic [63:0] ival;
        logic [30:0] alen;
        logic [3:0]  closed;
        logic        done;
        logic [3:0]  depth;
    } parse_event_t;

    logic           aclk     = 1'b0;
    logic           aresetn  = 1'b0;
    logic           s_tvalid = 1'b0;
    logic           s_tready;
    logic [7:0]     s_tdata  = 8'h00;
    logic           m_tvalid;
    logic           m_tready = 1'b0;
    logic [111:0]   m_tdata;    // [7:0] data_byte, [71:8] int_value, [102:72] array_length,
                                // [106:103] arrays_closed, [110:107] nest_depth, [111] zero
    logic [3:0]     m_tuser;    // [3:0] event_res
    logic           m_tlast;    // message_done

    logic           idle_enabled = 1'b1;
    int             beats_sent   = 0;
    int             mismatches   = 0;
    int             stall_cycles = 0;

    parse_event_t   pending_events[$];
    logic [7:0]     frame_q[$];

    // parser model state
    parse_state_t   p_state;
    logic [63:0]    p_acc;
    logic           p_neg;
    logic           p_digits;
    logic [30:0]    p_bulk;
    int             p_level;
    logic [30:0]    p_remain [PARSE_DEPTH];

    resp_stream_parser_unit #(
        .MAX_DEPTH(PARSE_DEPTH)
    ) DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #1 aclk = ~aclk;

    // ---------------------------------------------------------------- model
    function automatic void clear_number();
        p_acc    = '0;
        p_neg    = 1'b0;
        p_digits = 1'b0;
    endfunction

    function automatic void reset_parser();
        p_state = PS_START;
        clear_number();
        p_bulk  = '0;
        p_level = 0;
        foreach (p_remain[i]) p_remain[i] = '0;
    endfunction

    // digit states; CR moves on to the matching LF state
    function automatic logic number_byte(input logic [7:0] c, input logic sat);
        logic ok;
        ok = 1'b1;
        if (c == CH_CR) begin
            if (!p_digits) ok = 1'b0;
            else p_state = parse_state_t'(p_state + 4'd1);
        end else if (c >= CH_ZERO && c <= CH_NINE) begin
            if (sat && p_acc >= LEN_SAT) begin
                p_acc = LEN_SAT;
            end else begin
                p_acc = p_acc * 64'd10 + (c - CH_ZERO);
                if (sat && p_acc > LEN_SAT) p_acc = LEN_SAT;
            end
            p_digits = 1'b1;
        end else if (c == CH_MINUS && !p_digits && !p_neg) begin
            p_neg = 1'b1;
        end else begin
            ok = 1'b0;
        end
        return ok;
    endfunction

    function automatic parse_event_t parse_byte(input logic [7:0] c);
        parse_event_t r;
        logic         ended;
        logic         err;
        logic         unwinding;
        logic         is_array;
        logic [63:0]  n;
        int           top;
        r        = '0;
        r.ev     = EV_NONE;
        ended    = 1'b0;
        err      = 1'b0;
        case (p_state)
            PS_START: begin
                clear_number();
                case (c)
                    CH_PLUS:   p_state = PS_SIMPLE;
                    CH_MINUS:  p_state = PS_ERRSTR;
                    CH_COLON:  p_state = PS_INT;
                    CH_DOLLAR: p_state = PS_BSIZE;
                    CH_STAR:   p_state = PS_ASIZE;
                    default:   err = 1'b1;
                endcase
            end
            PS_SIMPLE, PS_ERRSTR: begin
                if (c == CH_CR) begin
                    p_state = (p_state == PS_SIMPLE) ? PS_SIMPLE_LF : PS_ERRSTR_LF;
                end else if (c >= CH_SPACE && c <= CH_TILDE) begin
                    r.ev   = (p_state == PS_SIMPLE) ? EV_SBYTE : EV_EBYTE;
                    r.data = c;
                end else begin
                    err = 1'b1;
                end
            end
            PS_SIMPLE_LF, PS_ERRSTR_LF, PS_BULK_LF: begin
                if (c == CH_LF) begin
                    r.ev = (p_state == PS_SIMPLE_LF) ? EV_SEND :
                           (p_state == PS_ERRSTR_LF) ? EV_EEND : EV_BEND;
                    ended   = 1'b1;
                    p_state = PS_START;
                end else begin
                    err = 1'b1;
                end
            end
            PS_INT:             err = !number_byte(c, 1'b0);
            PS_BSIZE, PS_ASIZE: err = !number_byte(c, 1'b1);
            PS_INT_LF: begin
                if (c == CH_LF) begin
                    r.ival  = p_neg ? (64'd0 - p_acc) : p_acc;
                    r.ev    = EV_INT;
                    ended   = 1'b1;
                    p_state = PS_START;
                    clear_number();
                end else begin
                    err = 1'b1;
                end
            end
            PS_BSIZE_LF, PS_ASIZE_LF: begin
                is_array = (p_state == PS_ASIZE_LF);
                n        = p_acc;
                if (c != CH_LF) begin
                    err = 1'b1;
                end else if (p_neg && n == 64'd1) begin
                    r.ev    = EV_NIL;
                    ended   = 1'b1;
                    p_state = PS_START;
                end else if (p_neg && n != 64'd0) begin
                    err = 1'b1;
                end else if (n > LEN_MAX) begin
                    err = 1'b1;
                end else if (n == 64'd0) begin
                    if (is_array) begin
                        r.ev    = EV_EMPTY;
                        ended   = 1'b1;
                        p_state = PS_START;
                    end else begin
                        p_state = PS_BULK_CR;
                    end
                end else if (is_array) begin
                    if (p_level >= PARSE_DEPTH) begin
                        err = 1'b1;
                    end else begin
                        p_remain[p_level] = n[30:0];
                        p_level           = p_level + 1;
                        r.ev              = EV_ARRAY;
                        r.alen            = n[30:0];
                        p_state           = PS_START;
                    end
                end else begin
                    p_bulk  = n[30:0];
                    p_state = PS_BULK;
                end
                clear_number();
            end
            PS_BULK: begin
                r.ev   = EV_BBYTE;
                r.data = c;
                if (p_bulk > 0) p_bulk = p_bulk - 31'd1;
                if (p_bulk == 0) p_state = PS_BULK_CR;
            end
            PS_BULK_CR: begin
                if (c == CH_CR) p_state = PS_BULK_LF;
                else err = 1'b1;
            end
            default: err = 1'b1;
        endcase

        if (err) begin
            reset_parser();
            r    = '0;
            r.ev = EV_ERROR;
        end else if (ended) begin
            // a finished value counts against every array it completes
            unwinding = 1'b1;
            while (unwinding && p_level > 0) begin
                top = p_level - 1;
                if (p_remain[top] > 0) p_remain[top] = p_remain[top] - 31'd1;
                if (p_remain[top] != 0) begin
                    unwinding = 1'b0;
                end else begin
                    p_level  = p_level - 1;
                    r.closed = r.closed + 4'd1;
                end
            end
            r.done = (p_level == 0);
        end
        r.depth = p_level[3:0];
        return r;
    endfunction

    // ---------------------------------------------------------------- checking
    function automatic void compare_field(input string name, input logic [63:0] want,
                                          input logic [63:0] got);
        if (got !== want) begin
            mismatches = mismatches + 1;
            if (mismatches <= 10)
                $display("mismatch on %s: expected %0h, got %0h", name, want, got);
        end
    endfunction

    always @(posedge aclk) begin : scoreboard
        parse_event_t want;
        parse_event_t next_ev;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (pending_events.size() == 0) begin
                    mismatches = mismatches + 1;
                    if (mismatches <= 10)
                        $display("result beat with no event pending: tuser %0h", m_tuser);
                end else begin
                    want = pending_events.pop_front();
                    compare_field("event_res",     64'(want.ev),     64'(m_tuser));
                    compare_field("data_byte",     64'(want.data),   64'(m_tdata[7:0]));
                    compare_field("int_value",     want.ival,        m_tdata[71:8]);
                    compare_field("array_length",  64'(want.alen),   64'(m_tdata[102:72]));
                    compare_field("arrays_closed", 64'(want.closed), 64'(m_tdata[106:103]));
                    compare_field("nest_depth",    64'(want.depth),  64'(m_tdata[110:107]));
                    compare_field("tdata pad",     64'd0,            64'(m_tdata[111]));
                    compare_field("message_done",  64'(want.done),   64'(m_tlast));
                end
            end
            if (s_tvalid && s_tready) begin
                next_ev = parse_byte(s_tdata);
                pending_events.insert(pending_events.size(), next_ev);
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) m_tready <= 1'b0;
        else m_tready <= !(idle_enabled && ($urandom_range(0, 99) < IDLE_PCT));
    end

    // ---------------------------------------------------------------- stimulus
    task automatic send_byte(input logic [7:0] b);
        while (idle_enabled && ($urandom_range(0, 99) < IDLE_PCT)) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge aclk); while (!s_tready);
        beats_sent = beats_sent + 1;
    endtask

    task automatic send_frame();
        foreach (frame_q[i]) send_byte(frame_q[i]);
        frame_q.delete();
    endtask

    task automatic wait_results_drained();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending_events.size() != 0);
    endtask

    function automatic void put_byte(input logic [7:0] b);
        frame_q.insert(frame_q.size(), b);
    endfunction

    function automatic void put_str(input string s);
        for (int i = 0; i < s.len(); i++) put_byte(s[i]);
    endfunction

    function automatic void put_eol();
        put_byte(CH_CR);
        put_byte(CH_LF);
    endfunction

    function automatic void put_dec(input logic [63:0] v);
        put_str($sformatf("%0d", v));
    endfunction

    function automatic void put_digits(input int count);
        repeat (count) put_byte(CH_ZERO + 8'($urandom_range(0, 9)));
    endfunction

    function automatic void put_integer();
        put_byte(CH_COLON);
        case ($urandom_range(0, 5))
            0: put_dec(64'($urandom_range(0, 999)));
            1: begin put_byte(CH_MINUS); put_dec(64'($urandom_range(0, 999))); end
            2: begin
                if ($urandom_range(0, 1)) put_byte(CH_MINUS);
                put_dec({$urandom, $urandom});
            end
            3: put_str("9223372036854775807");
            4: put_str("-9223372036854775808");
            default: begin
                // 20 to 24 digits, which can wrap past 64 bits
                if ($urandom_range(0, 1)) put_byte(CH_MINUS);
                put_digits($urandom_range(20, 24));
            end
        endcase
        put_eol();
    endfunction

    // one well-formed reply value, non-empty arrays only in the upper levels
    function automatic void add_value(input int depth);
        int n;
        case ($urandom_range(0, (depth < 3) ? 5 : 4))
            0, 1: begin
                put_byte((depth[0] ^ $urandom_range(0, 1)) ? CH_PLUS : CH_MINUS);
                repeat ($urandom_range(0, 5)) put_byte(8'($urandom_range(32, 126)));
                put_eol();
            end
            2: put_integer();
            3: begin
                n = $urandom_range(0, 9);
                if (n == 0) begin
                    put_str("$-1"); put_eol();
                end else if (n == 1) begin
                    put_str("$-0"); put_eol(); put_eol();
                end else begin
                    n = $urandom_range(0, 6);
                    put_byte(CH_DOLLAR);
                    if ($urandom_range(0, 3) == 0) put_byte(CH_ZERO);
                    put_dec(64'(n));
                    put_eol();
                    repeat (n) put_byte(8'($urandom_range(0, 255)));
                    put_eol();
                end
            end
            4: begin
                case ($urandom_range(0, 2))
                    0: put_str("*-1");
                    1: put_str("*0");
                    default: put_str("*-0");
                endcase
                put_eol();
            end
            default: begin
                n = $urandom_range(1, 3);
                put_byte(CH_STAR);
                put_dec(64'(n));
                put_eol();
                repeat (n) add_value(depth + 1);
            end
        endcase
    endfunction

    // malformed or boundary sequences
    function automatic void add_broken();
        int k;
        case ($urandom_range(0, 12))
            0: put_byte(8'($urandom_range(0, 255)));
            1: begin
                put_byte($urandom_range(0, 1) ? CH_PLUS : CH_MINUS);
                put_str("a");
                put_byte($urandom_range(0, 1) ? 8'($urandom_range(0, 31))
                                              : 8'($urandom_range(127, 255)));
            end
            2: begin
                put_str("+a");
                put_byte(CH_CR);
                put_byte(8'($urandom_range(0, 255)));
            end
            3: put_str(":1-");
            4: begin
                case ($urandom_range(0, 2))
                    0: put_byte(CH_COLON);
                    1: put_byte(CH_DOLLAR);
                    default: put_byte(CH_STAR);
                endcase
                if ($urandom_range(0, 1)) put_byte(CH_MINUS);
                put_byte(CH_CR);
            end
            5: put_str("*--");
            6: begin
                put_byte($urandom_range(0, 1) ? CH_DOLLAR : CH_STAR);
                if ($urandom_range(0, 1)) put_dec(64'h8000_0000 + 64'($urandom_range(0, 99)));
                else put_digits($urandom_range(11, 25));
                put_eol();
            end
            7: begin
                put_byte($urandom_range(0, 1) ? CH_DOLLAR : CH_STAR);
                put_byte(CH_MINUS);
                put_dec(64'($urandom_range(2, 99)));
                put_eol();
            end
            8: begin
                // deep nesting, one past the limit at the top of the range
                k = $urandom_range(6, 9);
                repeat (k) begin put_str("*1"); put_eol(); end
                add_value(3);
            end
            9: begin
                put_str("*2147483647"); put_eol();
                add_value(1);
                put_str("x");
            end
            10: put_str(":1a");
            11: begin put_str("$1"); put_eol(); put_str("ab"); end
            default: begin
                add_value(0);
                k = $urandom_range(1, 3);
                while (k > 0 && frame_q.size() > 1) begin
                    void'(frame_q.pop_back());
                    k = k - 1;
                end
            end
        endcase
    endfunction

    task automatic run_traffic(input int items, input int broken_pct);
        int target;
        int pick;
        target = beats_sent + items;
        while (beats_sent < target) begin
            pick = $urandom_range(0, 99);
            if (pick >= broken_pct) add_value(0);
            else if (pick < broken_pct / 2) repeat ($urandom_range(1, 3))
                put_byte(8'($urandom_range(0, 255)));
            else add_broken();
            send_frame();
        end
    endtask

    // ---------------------------------------------------------------- tests
    task automatic test_reply_events();
        put_str("+a");  put_eol();
        put_str("-~");  put_eol();
        put_str(":7");  put_eol();
        put_str("$1");  put_eol(); put_byte(8'hFF); put_eol();
        put_str("*-1"); put_eol();
        put_str("*0");  put_eol();
        put_byte(8'h00);
        send_frame();
    endtask

    task automatic test_wellformed_replies();
        run_traffic(250, 0);
    endtask

    task automatic test_malformed_input();
        run_traffic(120, 70);
    endtask

    task automatic test_back_to_back();
        idle_enabled <= 1'b0;
        run_traffic(180, 30);
        idle_enabled <= 1'b1;
    endtask

    initial begin
        reset_parser();
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        test_reply_events();
        test_wellformed_replies();
        wait_results_drained();
        test_malformed_input();
        test_back_to_back();

        wait_results_drained();
        repeat (20) @(posedge aclk);
        if (mismatches == 0 && pending_events.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
